@@ rtl/smi_pkg.sv @@
package smi_pkg;

  localparam int ELEM_W = 32;
  localparam int PROD_W = 64;
  localparam int DET_W  = 98;
  localparam int DMAG_W = 97;
  localparam int REM_W  = 98;
  localparam int QW     = 32;
  localparam int NENT   = 9;

  typedef logic [3:0] idx_t;

  // Adjugate entry (r,k), i.e. cofactor (k,r), = a[i0]*a[i1] - a[i2]*a[i3], flat index r*3+k
  localparam idx_t CF_IDX [NENT][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd8, 4'd1},
    '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd5, 4'd6, 4'd8, 4'd3},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd5, 4'd0},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd1, 4'd6, 4'd7, 4'd0},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]        size;
    logic              sing;
    logic [ELEM_W-1:0] det_value;
    logic [NENT-1:0]   neg;
    logic [NENT-1:0]   ovf;
  } side_t;

endpackage

@@ rtl/smi_div_pipe.sv @@
module smi_div_pipe import smi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [DMAG_W-1:0] in_d,
  input  logic [REM_W-1:0]  in_rem [NENT],
  input  logic [QW-1:0]     in_lowq [NENT],
  output logic              out_valid,
  output side_t             out_side,
  output logic [QW-1:0]     out_q [NENT]
);

  logic              v      [QW];
  side_t             side_r [QW];
  logic [DMAG_W-1:0] d_r    [QW];
  logic [REM_W-1:0]  rem_r  [QW][NENT];
  logic [QW-1:0]     lq_r   [QW][NENT];

  logic [REM_W-1:0]  rem_next [QW][NENT];
  logic [QW-1:0]     lq_next  [QW][NENT];

  // Operands seen by each stage: the inputs for the first, the previous stage otherwise
  logic [REM_W-1:0]  src_rem [QW][NENT];
  logic [QW-1:0]     src_lq  [QW][NENT];
  logic [DMAG_W-1:0] src_d   [QW];

  always_comb begin
    src_d[0] = in_d;
    for (int i = 0; i < NENT; i++) begin
      src_rem[0][i] = in_rem[i];
      src_lq[0][i]  = in_lowq[i];
    end
    for (int s = 1; s < QW; s++) begin
      src_d[s] = d_r[s-1];
      for (int i = 0; i < NENT; i++) begin
        src_rem[s][i] = rem_r[s-1][i];
        src_lq[s][i]  = lq_r[s-1][i];
      end
    end
  end

  // One quotient bit per stage: shift in the next numerator bit, subtract if it fits
  always_comb begin
    logic [REM_W-1:0] dd;
    logic [REM_W-1:0] r2;
    logic             ge;
    for (int s = 0; s < QW; s++) begin
      for (int i = 0; i < NENT; i++) begin
        dd      = REM_W'(src_d[s]);
        r2      = {src_rem[s][i][REM_W-2:0], src_lq[s][i][QW-1]};
        ge      = (r2 >= dd);
        rem_next[s][i] = ge ? (r2 - dd) : r2;
        lq_next[s][i]  = {src_lq[s][i][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < QW; s++) begin
        v[s] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= in_valid;
      for (int s = 1; s < QW; s++) begin
        v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int s = 1; s < QW; s++) begin
        side_r[s] <= side_r[s-1];
      end
      for (int s = 0; s < QW; s++) begin
        d_r[s] <= src_d[s];
        for (int i = 0; i < NENT; i++) begin
          rem_r[s][i] <= rem_next[s][i];
          lq_r[s][i]  <= lq_next[s][i];
        end
      end
    end
  end

  assign out_valid = v[QW-1];
  assign out_side  = side_r[QW-1];
  always_comb begin
    for (int i = 0; i < NENT; i++) begin
      out_q[i] = lq_r[QW-1][i];
    end
  end

endmodule

@@ rtl/small_matrix_inverse_top.sv @@
// Inverse and determinant of a 1x1, 2x2 or 3x3 signed fixed-point matrix (FRAC_BITS
// fraction bits). Only the leading matrix_size block of the nine elements is used;
// smaller orders are padded to 3x3 with ones on the diagonal. Each inverse entry is
// the adjugate entry scaled by 2^(2*FRAC_BITS) divided by the exact determinant, truncated
// toward zero and saturated to 32 bits; det_value is the determinant saturated to 32
// bits. A zero determinant, or a matrix_size of zero, raises singular with all other
// outputs zero. The block takes one matrix per clock while the output is not stalled,
// passing it through cofactor and determinant arithmetic, a bit-per-stage pipelined
// divider (one quotient bit per stage, nine lanes in parallel), and the output
// register. Any stall at the output holds the whole pipeline.
module small_matrix_inverse_top import smi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               matrix_size,
  input  logic signed [ELEM_W-1:0] a00,
  input  logic signed [ELEM_W-1:0] a01,
  input  logic signed [ELEM_W-1:0] a02,
  input  logic signed [ELEM_W-1:0] a10,
  input  logic signed [ELEM_W-1:0] a11,
  input  logic signed [ELEM_W-1:0] a12,
  input  logic signed [ELEM_W-1:0] a20,
  input  logic signed [ELEM_W-1:0] a21,
  input  logic signed [ELEM_W-1:0] a22,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ELEM_W-1:0] inv00,
  output logic signed [ELEM_W-1:0] inv01,
  output logic signed [ELEM_W-1:0] inv02,
  output logic signed [ELEM_W-1:0] inv10,
  output logic signed [ELEM_W-1:0] inv11,
  output logic signed [ELEM_W-1:0] inv12,
  output logic signed [ELEM_W-1:0] inv20,
  output logic signed [ELEM_W-1:0] inv21,
  output logic signed [ELEM_W-1:0] inv22,
  output logic signed [ELEM_W-1:0] det_value,
  output logic                     singular
);

  localparam int SH    = 2 * FRAC_BITS;
  localparam int NUM_W = PROD_W + SH;
  localparam logic [ELEM_W-1:0] ONE = ELEM_W'(64'd1 << FRAC_BITS);

  // Advance everything together; hold when the output request is not taken
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: capture with identity padding
  logic signed [ELEM_W-1:0] in_m [NENT];
  logic signed [ELEM_W-1:0] emb  [NENT];
  logic                     v1;
  logic signed [ELEM_W-1:0] a1 [NENT];
  logic [1:0]               sz1;

  always_comb begin
    in_m = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
    for (int e = 0; e < NENT; e++) begin
      if ((e / 3) < int'(matrix_size) && (e % 3) < int'(matrix_size)) begin
        emb[e] = in_m[e];
      end else if ((e / 3) == (e % 3)) begin
        emb[e] = ONE;
      end else begin
        emb[e] = '0;
      end
    end
  end

  // Stage 2: eighteen cofactor products
  logic                     v2;
  logic signed [PROD_W-1:0] p2 [2*NENT];
  logic signed [ELEM_W-1:0] r0_2 [3];
  logic [1:0]               sz2;

  // Stage 3: cofactors
  logic                     v3;
  logic signed [PROD_W-1:0] c3 [NENT];
  logic signed [ELEM_W-1:0] r0_3 [3];
  logic [1:0]               sz3;

  // Stage 4: determinant partial products, split on the cofactor halves
  logic                     v4;
  logic signed [PROD_W:0]   plo4 [3];
  logic signed [PROD_W-1:0] phi4 [3];
  logic signed [PROD_W-1:0] c4 [NENT];
  logic [1:0]               sz4;

  // Stage 5: determinant terms
  logic                     v5;
  logic signed [DET_W-1:0]  t5 [3];
  logic signed [PROD_W-1:0] c5 [NENT];
  logic [1:0]               sz5;

  // Stage 6: determinant
  logic                     v6;
  logic signed [DET_W-1:0]  det6;
  logic signed [PROD_W-1:0] c6 [NENT];
  logic [1:0]               sz6;

  // Stage 7: magnitudes and signs
  logic                     v7;
  logic [DMAG_W-1:0]        dmag7;
  logic                     dneg7;
  logic                     dzero7;
  logic [PROD_W-1:0]        cmag7 [NENT];
  logic [NENT-1:0]          cneg7;
  logic [1:0]               sz7;

  // Stage 8: divider setup
  logic                     v8;
  side_t                    side8;
  logic [DMAG_W-1:0]        d8;
  logic [REM_W-1:0]         rem8 [NENT];
  logic [QW-1:0]            lowq8 [NENT];

  logic [DET_W-1:0] dabs6;
  logic [DMAG_W-1:0] dsh7;
  logic [ELEM_W-1:0] dval7;
  logic [NUM_W-1:0]  num7 [NENT];

  always_comb begin
    dabs6 = det6[DET_W-1] ? (~det6 + 1'b1) : det6;
    dsh7  = dmag7 >> SH;
    if (!dneg7) begin
      dval7 = (|dsh7[DMAG_W-1:ELEM_W-1]) ? SAT_POS : dsh7[ELEM_W-1:0];
    end else if ((|dsh7[DMAG_W-1:ELEM_W]) || (dsh7[ELEM_W-1] && (|dsh7[ELEM_W-2:0]))) begin
      dval7 = SAT_NEG;
    end else begin
      dval7 = ~dsh7[ELEM_W-1:0] + 1'b1;
    end
    for (int i = 0; i < NENT; i++) begin
      num7[i] = {cmag7[i], {SH{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= emb;
      sz1 <= matrix_size;

      for (int i = 0; i < NENT; i++) begin
        p2[2*i]   <= a1[CF_IDX[i][0]] * a1[CF_IDX[i][1]];
        p2[2*i+1] <= a1[CF_IDX[i][2]] * a1[CF_IDX[i][3]];
      end
      r0_2 <= '{a1[0], a1[1], a1[2]};
      sz2  <= sz1;

      for (int i = 0; i < NENT; i++) begin
        c3[i] <= p2[2*i] - p2[2*i+1];
      end
      r0_3 <= r0_2;
      sz3  <= sz2;

      // det = a00*c00 + a01*c10 + a02*c20
      for (int j = 0; j < 3; j++) begin
        plo4[j] <= r0_3[j] * $signed({1'b0, c3[3*j][ELEM_W-1:0]});
        phi4[j] <= r0_3[j] * $signed(c3[3*j][PROD_W-1:ELEM_W]);
      end
      c4  <= c3;
      sz4 <= sz3;

      for (int j = 0; j < 3; j++) begin
        t5[j] <= ({{(DET_W-PROD_W){phi4[j][PROD_W-1]}}, phi4[j]} <<< ELEM_W)
               + {{(DET_W-PROD_W-1){plo4[j][PROD_W]}}, plo4[j]};
      end
      c5  <= c4;
      sz5 <= sz4;

      det6 <= t5[0] + t5[1] + t5[2];
      c6   <= c5;
      sz6  <= sz5;

      dmag7  <= dabs6[DMAG_W-1:0];
      dneg7  <= det6[DET_W-1];
      dzero7 <= (det6 == '0);
      for (int i = 0; i < NENT; i++) begin
        cmag7[i] <= c6[i][PROD_W-1] ? (~c6[i] + 1'b1) : c6[i];
        cneg7[i] <= c6[i][PROD_W-1];
      end
      sz7 <= sz6;

      // Quotient at or above 2^32 saturates: flag it and skip those bits
      d8 <= dmag7;
      for (int i = 0; i < NENT; i++) begin
        rem8[i]      <= REM_W'(num7[i][NUM_W-1:QW]);
        lowq8[i]     <= num7[i][QW-1:0];
        side8.ovf[i] <= (REM_W'(num7[i][NUM_W-1:QW]) >= REM_W'(dmag7));
        side8.neg[i] <= cneg7[i] ^ dneg7;
      end
      side8.size      <= sz7;
      side8.sing      <= dzero7 || (sz7 == 2'd0);
      side8.det_value <= dval7;
    end
  end

  logic          vq;
  side_t         sideq;
  logic [QW-1:0] q [NENT];

  smi_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .in_side   (side8),
    .in_d      (d8),
    .in_rem    (rem8),
    .in_lowq   (lowq8),
    .out_valid (vq),
    .out_side  (sideq),
    .out_q     (q)
  );

  // Output: saturate, drop entries outside the used block, zero on singular
  logic [ELEM_W-1:0] res [NENT];
  logic [ELEM_W-1:0] ent [NENT];

  always_comb begin
    for (int i = 0; i < NENT; i++) begin
      if (!sideq.neg[i]) begin
        ent[i] = (sideq.ovf[i] || q[i][QW-1]) ? SAT_POS : q[i];
      end else if (sideq.ovf[i] || (q[i] > SAT_NEG)) begin
        ent[i] = SAT_NEG;
      end else begin
        ent[i] = ~q[i] + 1'b1;
      end
      if (sideq.sing || (i / 3) >= int'(sideq.size) || (i % 3) >= int'(sideq.size)) begin
        res[i] = '0;
      end else begin
        res[i] = ent[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv00     <= res[0];
      inv01     <= res[1];
      inv02     <= res[2];
      inv10     <= res[3];
      inv11     <= res[4];
      inv12     <= res[5];
      inv20     <= res[6];
      inv21     <= res[7];
      inv22     <= res[8];
      det_value <= sideq.sing ? '0 : sideq.det_value;
      singular  <= sideq.sing;
    end
  end

endmodule
